### hw/rtl/pfa_pkg.sv
// Shared constants, codes and types of the page frame allocator.
// Used by the RAM-backed top level and by its port checker; no dependencies.
`timescale 1ns / 1ps

package pfa_pkg;

    localparam int NUM_PAGES    = 32768;
    localparam int HUGE_RUN     = 1024;

    localparam int PAGE_W       = $clog2(NUM_PAGES);
    localparam int CNT_W        = PAGE_W + 1;
    localparam int RUN_CW       = $clog2(HUGE_RUN + 1);
    localparam int CMP_W        = ((CNT_W > 16) ? CNT_W : 16) + 1;

    localparam int PAGE_FIELD_W = 15;
    localparam int GRANT_W      = 11;
    localparam int REG_W        = 16;
    localparam int REG_IDX_W    = 2;
    localparam int MARK_W       = 2;

    // Mark memory bits.
    localparam int MARK_FREE = 0;
    localparam int MARK_HUGE = 1;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_HUGE  = 2'd2,
        OP_FREE  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_DOUBLE = 2'd2
    } status_t;

    localparam logic [REG_IDX_W-1:0] REG_PAGES_IN_USE = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_HOLE_START   = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_HOLE_END     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_KERNEL_END   = 2'd3;

endpackage

### hw/rtl/pfa_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
`timescale 1ns / 1ps

module pfa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### hw/rtl/page_frame_allocator.sv
// Page frame allocator top level: control sequencer around the link and mark RAMs.
// Depends on pfa_pkg and pfa_ram.
`timescale 1ns / 1ps

// The allocator keeps physical pages on a LIFO free list held in a link RAM,
// with a two-bit mark RAM (free, huge) per page. Each request returns exactly
// one response. After reset a clearing pass wipes the mark RAM; requests are
// not accepted until it ends, while configuration writes are taken at any
// time. Init clears and lists one page per cycle. A free of a huge block
// reads each page of the block and relists those not already free; a huge
// allocate scans the marks up to the first fitting run, walks the free list
// to unlink the run's pages and then clears the run's marks. A new request
// is taken while the previous response still waits in the output register.
module page_frame_allocator (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [1:0]                         s_operation,
    input  logic                               s_zero_wanted,
    input  logic [14:0]                        s_page_number,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [14:0]                        m_page_out,
    output logic [1:0]                         m_status,
    output logic                               m_clear_request,
    output logic [10:0]                        m_pages_granted,
    input  logic                               cfg_we,
    input  logic [pfa_pkg::REG_IDX_W-1:0]      cfg_index,
    input  logic [pfa_pkg::REG_W-1:0]          cfg_wdata
);
    import pfa_pkg::*;

    typedef enum logic [10:0] {
        S_CLEAR = 11'b000_0000_0001,
        S_IDLE  = 11'b000_0000_0010,
        S_INIT  = 11'b000_0000_0100,
        S_ALLOC = 11'b000_0000_1000,
        S_FREE  = 11'b000_0001_0000,
        S_HF_RD = 11'b000_0010_0000,
        S_HF_WT = 11'b000_0100_0000,
        S_SCAN  = 11'b000_1000_0000,
        S_WK_RD = 11'b001_0000_0000,
        S_WK_WT = 11'b010_0000_0000,
        S_MCLR  = 11'b100_0000_0000
    } state_t;

    // The emit step is folded in as a flag so the enum stays compact.
    state_t                 state_reg, state_next;
    logic                   emit_reg, emit_next;

    logic [REG_W-1:0]       pages_reg, pages_next;
    logic [REG_W-1:0]       hstart_reg, hstart_next;
    logic [REG_W-1:0]       hend_reg, hend_next;
    logic [REG_W-1:0]       kend_reg, kend_next;

    logic [PAGE_W-1:0]      head_reg, head_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       idx_reg, idx_next;
    logic                   zero_reg, zero_next;
    logic [PAGE_W-1:0]      pg_reg, pg_next;
    logic [PAGE_W-1:0]      start_reg, start_next;
    logic [RUN_CW-1:0]      run_reg, run_next;
    logic                   rdp_reg, rdp_next;
    logic [CNT_W-1:0]       rdi_reg, rdi_next;
    logic [PAGE_W-1:0]      cur_reg, cur_next;
    logic [CNT_W-1:0]       left_reg, left_next;
    logic [CNT_W-1:0]       kept_reg, kept_next;
    logic [PAGE_W-1:0]      first_reg, first_next;
    logic [PAGE_W-1:0]      prev_reg, prev_next;

    logic [PAGE_W-1:0]      rpage_reg, rpage_next;
    status_t                rstat_reg, rstat_next;
    logic                   rclr_reg, rclr_next;
    logic [GRANT_W-1:0]     rgrant_reg, rgrant_next;

    logic                   mv_reg, mv_next;
    logic [14:0]            mpage_reg, mpage_next;
    logic [1:0]             mstat_reg, mstat_next;
    logic                   mclr_reg, mclr_next;
    logic [10:0]            mgrant_reg, mgrant_next;

    logic                   link_we;
    logic [PAGE_W-1:0]      link_waddr, link_raddr, link_rdata;
    logic [PAGE_W-1:0]      link_wdata;
    logic                   mark_we;
    logic [PAGE_W-1:0]      mark_waddr, mark_raddr;
    logic [MARK_W-1:0]      mark_wdata, mark_rdata;

    logic [CMP_W-1:0]       end_pages, ix, pgx, qx, curx, startx, runstart;
    logic                   push_ok, accept;

    pfa_ram #(.WIDTH(PAGE_W), .DEPTH(NUM_PAGES)) u_link_ram (
        .aclk  (aclk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    pfa_ram #(.WIDTH(MARK_W), .DEPTH(NUM_PAGES)) u_mark_ram (
        .aclk  (aclk),
        .we    (mark_we),
        .waddr (mark_waddr),
        .wdata (mark_wdata),
        .raddr (mark_raddr),
        .rdata (mark_rdata)
    );

    assign s_ready         = (state_reg == S_IDLE) && !emit_reg;
    assign accept          = s_valid && s_ready;
    assign m_valid         = mv_reg;
    assign m_page_out      = mpage_reg;
    assign m_status        = mstat_reg;
    assign m_clear_request = mclr_reg;
    assign m_pages_granted = mgrant_reg;

    // End of memory is the smaller of the register and the table depth.
    assign end_pages = (CMP_W'(pages_reg) < CMP_W'(NUM_PAGES)) ?
                       CMP_W'(pages_reg) : CMP_W'(NUM_PAGES);
    assign ix        = CMP_W'(idx_reg);
    assign pgx       = CMP_W'(s_page_number);
    assign qx        = CMP_W'(pg_reg) + CMP_W'(idx_reg);
    assign curx      = CMP_W'(cur_reg);
    assign startx    = CMP_W'(start_reg);
    assign runstart  = CMP_W'(rdi_reg) + CMP_W'(1) - CMP_W'(HUGE_RUN);

    // A page is listed at init unless it is page zero, beyond memory, in the
    // I/O hole, or in the kernel area.
    assign push_ok = (ix >= CMP_W'(1)) && (ix < end_pages) &&
                     !((ix >= CMP_W'(hstart_reg)) && (ix < CMP_W'(hend_reg))) &&
                     !((ix >= CMP_W'(hend_reg)) && (ix < CMP_W'(kend_reg)));

    always_comb begin
        state_next  = state_reg;
        emit_next   = emit_reg;
        pages_next  = pages_reg;
        hstart_next = hstart_reg;
        hend_next   = hend_reg;
        kend_next   = kend_reg;
        head_next   = head_reg;
        count_next  = count_reg;
        idx_next    = idx_reg;
        zero_next   = zero_reg;
        pg_next     = pg_reg;
        start_next  = start_reg;
        run_next    = run_reg;
        rdp_next    = rdp_reg;
        rdi_next    = rdi_reg;
        cur_next    = cur_reg;
        left_next   = left_reg;
        kept_next   = kept_reg;
        first_next  = first_reg;
        prev_next   = prev_reg;
        rpage_next  = rpage_reg;
        rstat_next  = rstat_reg;
        rclr_next   = rclr_reg;
        rgrant_next = rgrant_reg;
        mv_next     = mv_reg && !m_ready;
        mpage_next  = mpage_reg;
        mstat_next  = mstat_reg;
        mclr_next   = mclr_reg;
        mgrant_next = mgrant_reg;

        link_we     = 1'b0;
        link_waddr  = prev_reg;
        link_wdata  = cur_reg;
        link_raddr  = cur_reg;
        mark_we     = 1'b0;
        mark_waddr  = idx_reg[PAGE_W-1:0];
        mark_wdata  = '0;
        mark_raddr  = idx_reg[PAGE_W-1:0];

        if (cfg_we) begin
            case (cfg_index)
                REG_PAGES_IN_USE: pages_next  = cfg_wdata;
                REG_HOLE_START:   hstart_next = cfg_wdata;
                REG_HOLE_END:     hend_next   = cfg_wdata;
                REG_KERNEL_END:   kend_next   = cfg_wdata;
                default: ;
            endcase
        end

        if (emit_reg) begin
            if (!mv_reg || m_ready) begin
                mv_next     = 1'b1;
                mpage_next  = PAGE_FIELD_W'(rpage_reg);
                mstat_next  = rstat_reg;
                mclr_next   = rclr_reg;
                mgrant_next = rgrant_reg;
                emit_next   = 1'b0;
            end
        end else begin
            case (state_reg)
                S_CLEAR: begin
                    mark_we  = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                    if (idx_reg == CNT_W'(NUM_PAGES - 1)) begin
                        state_next = S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        zero_next   = s_zero_wanted;
                        rpage_next  = '0;
                        rstat_next  = ST_OK;
                        rclr_next   = 1'b0;
                        rgrant_next = '0;
                        case (op_t'(s_operation))
                            OP_INIT: begin
                                idx_next   = '0;
                                head_next  = '0;
                                count_next = '0;
                                state_next = S_INIT;
                            end
                            OP_ALLOC: begin
                                if (count_reg == '0) begin
                                    rstat_next = ST_EMPTY;
                                    emit_next  = 1'b1;
                                end else begin
                                    link_raddr = head_reg;
                                    mark_we    = 1'b1;
                                    mark_waddr = head_reg;
                                    mark_wdata = '0;
                                    rpage_next = head_reg;
                                    state_next = S_ALLOC;
                                end
                            end
                            OP_HUGE: begin
                                if (count_reg == '0) begin
                                    rstat_next = ST_EMPTY;
                                    emit_next  = 1'b1;
                                end else begin
                                    idx_next   = '0;
                                    rdp_next   = 1'b0;
                                    run_next   = '0;
                                    state_next = S_SCAN;
                                end
                            end
                            default: begin
                                if (pgx >= CMP_W'(NUM_PAGES)) begin
                                    emit_next = 1'b1;
                                end else begin
                                    pg_next    = PAGE_W'(s_page_number);
                                    mark_raddr = PAGE_W'(s_page_number);
                                    state_next = S_FREE;
                                end
                            end
                        endcase
                    end
                end
                S_INIT: begin
                    // One page per cycle: clear its marks and list it if allowed.
                    mark_we  = 1'b1;
                    idx_next = idx_reg + CNT_W'(1);
                    if (push_ok) begin
                        mark_wdata[MARK_FREE] = 1'b1;
                        link_we    = 1'b1;
                        link_waddr = idx_reg[PAGE_W-1:0];
                        link_wdata = head_reg;
                        head_next  = idx_reg[PAGE_W-1:0];
                        count_next = count_reg + CNT_W'(1);
                    end
                    if (idx_reg == CNT_W'(NUM_PAGES - 1)) begin
                        state_next = S_IDLE;
                        emit_next  = 1'b1;
                    end
                end
                S_ALLOC: begin
                    head_next   = link_rdata;
                    count_next  = count_reg - CNT_W'(1);
                    rclr_next   = zero_reg;
                    rgrant_next = GRANT_W'(1);
                    state_next  = S_IDLE;
                    emit_next   = 1'b1;
                end
                S_FREE: begin
                    if (mark_rdata[MARK_FREE]) begin
                        rstat_next = ST_DOUBLE;
                        state_next = S_IDLE;
                        emit_next  = 1'b1;
                    end else if (mark_rdata[MARK_HUGE]) begin
                        idx_next   = '0;
                        state_next = S_HF_RD;
                    end else begin
                        link_we     = 1'b1;
                        link_waddr  = pg_reg;
                        link_wdata  = head_reg;
                        mark_we     = 1'b1;
                        mark_waddr  = pg_reg;
                        mark_wdata[MARK_FREE] = 1'b1;
                        head_next   = pg_reg;
                        count_next  = count_reg + CNT_W'(1);
                        rgrant_next = GRANT_W'(1);
                        state_next  = S_IDLE;
                        emit_next   = 1'b1;
                    end
                end
                S_HF_RD: begin
                    if ((CMP_W'(idx_reg) >= CMP_W'(HUGE_RUN)) ||
                        (qx >= CMP_W'(NUM_PAGES))) begin
                        state_next = S_IDLE;
                        emit_next  = 1'b1;
                    end else begin
                        mark_raddr = qx[PAGE_W-1:0];
                        state_next = S_HF_WT;
                    end
                end
                S_HF_WT: begin
                    if (!mark_rdata[MARK_FREE]) begin
                        link_we     = 1'b1;
                        link_waddr  = qx[PAGE_W-1:0];
                        link_wdata  = head_reg;
                        mark_we     = 1'b1;
                        mark_waddr  = qx[PAGE_W-1:0];
                        mark_wdata[MARK_FREE] = 1'b1;
                        head_next   = qx[PAGE_W-1:0];
                        count_next  = count_reg + CNT_W'(1);
                        rgrant_next = rgrant_reg + GRANT_W'(1);
                    end
                    idx_next   = idx_reg + CNT_W'(1);
                    state_next = S_HF_RD;
                end
                S_SCAN: begin
                    // Reads are pipelined: the mark of rdi_reg arrives now.
                    if (ix < end_pages) begin
                        mark_raddr = idx_reg[PAGE_W-1:0];
                        idx_next   = idx_reg + CNT_W'(1);
                        rdp_next   = 1'b1;
                        rdi_next   = idx_reg;
                    end else begin
                        rdp_next = 1'b0;
                    end
                    if (rdp_reg) begin
                        run_next = mark_rdata[MARK_FREE] ? run_reg + RUN_CW'(1) : '0;
                        if (mark_rdata[MARK_FREE] &&
                            (run_reg + RUN_CW'(1) >= RUN_CW'(HUGE_RUN))) begin
                            start_next = runstart[PAGE_W-1:0];
                            cur_next   = head_reg;
                            left_next  = count_reg;
                            kept_next  = '0;
                            state_next = S_WK_RD;
                        end
                    end else if (!(ix < end_pages)) begin
                        rstat_next = ST_EMPTY;
                        state_next = S_IDLE;
                        emit_next  = 1'b1;
                    end
                end
                S_WK_RD: begin
                    if (left_reg == '0) begin
                        head_next  = (kept_reg != '0) ? first_reg : '0;
                        count_next = kept_reg;
                        idx_next   = '0;
                        state_next = S_MCLR;
                    end else begin
                        link_raddr = cur_reg;
                        state_next = S_WK_WT;
                    end
                end
                S_WK_WT: begin
                    // Pages outside the run stay listed in their order.
                    if (!((curx >= startx) && (curx - startx < CMP_W'(HUGE_RUN)))) begin
                        if (kept_reg == '0) begin
                            first_next = cur_reg;
                        end else begin
                            link_we    = 1'b1;
                            link_waddr = prev_reg;
                            link_wdata = cur_reg;
                        end
                        prev_next = cur_reg;
                        kept_next = kept_reg + CNT_W'(1);
                    end
                    cur_next   = link_rdata;
                    left_next  = left_reg - CNT_W'(1);
                    state_next = S_WK_RD;
                end
                S_MCLR: begin
                    mark_we    = 1'b1;
                    mark_waddr = PAGE_W'(startx + ix);
                    mark_wdata[MARK_HUGE] = (idx_reg == '0);
                    idx_next   = idx_reg + CNT_W'(1);
                    if (CMP_W'(idx_reg) == CMP_W'(HUGE_RUN - 1)) begin
                        rpage_next  = start_reg;
                        rclr_next   = zero_reg;
                        rgrant_next = GRANT_W'(HUGE_RUN);
                        state_next  = S_IDLE;
                        emit_next   = 1'b1;
                    end
                end
                default: begin
                    state_next = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_CLEAR;
            emit_reg   <= 1'b0;
            idx_reg    <= '0;
            head_reg   <= '0;
            count_reg  <= '0;
            mv_reg     <= 1'b0;
            pages_reg  <= REG_W'(32768);
            hstart_reg <= REG_W'(160);
            hend_reg   <= REG_W'(256);
            kend_reg   <= REG_W'(512);
            rdp_reg    <= 1'b0;
        end else begin
            state_reg  <= state_next;
            emit_reg   <= emit_next;
            idx_reg    <= idx_next;
            head_reg   <= head_next;
            count_reg  <= count_next;
            mv_reg     <= mv_next;
            pages_reg  <= pages_next;
            hstart_reg <= hstart_next;
            hend_reg   <= hend_next;
            kend_reg   <= kend_next;
            rdp_reg    <= rdp_next;
        end
    end

    always_ff @(posedge aclk) begin
        zero_reg   <= zero_next;
        pg_reg     <= pg_next;
        start_reg  <= start_next;
        run_reg    <= run_next;
        rdi_reg    <= rdi_next;
        cur_reg    <= cur_next;
        left_reg   <= left_next;
        kept_reg   <= kept_next;
        first_reg  <= first_next;
        prev_reg   <= prev_next;
        rpage_reg  <= rpage_next;
        rstat_reg  <= rstat_next;
        rclr_reg   <= rclr_next;
        rgrant_reg <= rgrant_next;
        mpage_reg  <= mpage_next;
        mstat_reg  <= mstat_next;
        mclr_reg   <= mclr_next;
        mgrant_reg <= mgrant_next;
    end

endmodule

### hw/rtl/pfa_checker.sv
// Port-level checker for the page frame allocator, bound to the top level.
// Depends on pfa_pkg.
`timescale 1ns / 1ps

module pfa_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [14:0]                   m_page_out,
    input logic [1:0]                    m_status,
    input logic                          m_clear_request,
    input logic [10:0]                   m_pages_granted
);
    import pfa_pkg::*;

    // A stalled response stays offered.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("response dropped while stalled");

    // A failed allocation grants nothing and names no page.
    a_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_EMPTY) |->
            (m_page_out == '0) && (m_pages_granted == '0) && !m_clear_request)
        else $error("failed allocation carries data");

    // A double free changes nothing and reports nothing granted.
    a_double: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == ST_DOUBLE) |->
            (m_page_out == '0) && (m_pages_granted == '0) && !m_clear_request)
        else $error("double free carries data");

    // A clear request only comes with a successful allocation of pages.
    a_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_clear_request |->
            (m_status == ST_OK) && (m_pages_granted != '0))
        else $error("clear request without a granted allocation");

endmodule

bind page_frame_allocator pfa_checker u_pfa_checker (.*);

### tb/page_frame_allocator_checker.sv
// Response checker for the page frame allocator: predicts every response and compares it.
// Depends on pfa_pkg; watches the request, response and configuration ports of the block.
`timescale 1ns / 1ps

module page_frame_allocator_checker
    import pfa_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_operation,
    input  logic        s_zero_wanted,
    input  logic [14:0] s_page_number,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [14:0] m_page_out,
    input  logic [1:0]  m_status,
    input  logic        m_clear_request,
    input  logic [10:0] m_pages_granted,
    input  logic        cfg_we,
    input  logic [REG_IDX_W-1:0] cfg_index,
    input  logic [REG_W-1:0]     cfg_wdata,
    input  logic        drain_done,
    output int          fail_count
);

    typedef struct packed {
        logic [14:0] page;
        logic [1:0]  st;
        logic        clr;
        logic [10:0] cnt;
    } grant_t;

    grant_t      grants_due[$];
    int unsigned free_list[$];      // index 0 is the list head
    bit          free_mk [NUM_PAGES];
    bit          huge_mk [NUM_PAGES];
    logic [15:0] regs [4];
    bit          drain_checked;

    task automatic push_page(input int unsigned p);
        free_list.push_front(p);
        free_mk[p] = 1'b1;
        huge_mk[p] = 1'b0;
    endtask

    task automatic predict_grant(input logic [1:0] op, input logic zw, input logic [14:0] pg,
                                 output grant_t g);
        int unsigned n, run, start, cnt, q, p;
        bit found, hole, kern;
        int unsigned kept[$];
        g = '0;
        n = (regs[0] < NUM_PAGES) ? regs[0] : NUM_PAGES;
        found = 1'b0;
        start = 0;
        run = 0;
        cnt = 0;
        case (op)
            OP_INIT: begin
                for (int i = 0; i < NUM_PAGES; i++) begin
                    free_mk[i] = 1'b0;
                    huge_mk[i] = 1'b0;
                end
                free_list.delete();
                for (int unsigned i = 1; i < n; i++) begin
                    hole = (i >= regs[1]) && (i < regs[2]);
                    kern = (i >= regs[2]) && (i < regs[3]);
                    if (!hole && !kern) push_page(i);
                end
            end
            OP_ALLOC: begin
                if (free_list.size() == 0) begin
                    g.st = ST_EMPTY;
                end else begin
                    p = free_list.pop_front();
                    free_mk[p] = 1'b0;
                    huge_mk[p] = 1'b0;
                    g.page = p[14:0];
                    g.clr  = zw;
                    g.cnt  = 11'd1;
                end
            end
            OP_HUGE: begin
                for (int unsigned i = 0; i < n && !found; i++) begin
                    run = free_mk[i] ? run + 1 : 0;
                    if (run >= HUGE_RUN) begin
                        found = 1'b1;
                        start = i + 1 - HUGE_RUN;
                    end
                end
                if (free_list.size() == 0 || !found) begin
                    g.st = ST_EMPTY;
                end else begin
                    // Drop the run from the list but keep the order of the rest.
                    foreach (free_list[k])
                        if (!(free_list[k] >= start && free_list[k] - start < HUGE_RUN))
                            kept.push_back(free_list[k]);
                    free_list = kept;
                    for (int unsigned i = 0; i < HUGE_RUN; i++) free_mk[start + i] = 1'b0;
                    huge_mk[start] = 1'b1;
                    g.page = start[14:0];
                    g.clr  = zw;
                    g.cnt  = 11'(HUGE_RUN);
                end
            end
            default: begin
                if (free_mk[pg]) begin
                    g.st = ST_DOUBLE;
                end else if (huge_mk[pg]) begin
                    for (int unsigned i = 0; i < HUGE_RUN; i++) begin
                        q = pg + i;
                        if (q >= NUM_PAGES) break;
                        if (!free_mk[q]) begin
                            push_page(q);
                            cnt++;
                        end
                    end
                    g.cnt = cnt[10:0];
                end else begin
                    push_page(pg);
                    g.cnt = 11'd1;
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        grant_t g;
        if (!aresetn) begin
            grants_due.delete();
            free_list.delete();
            for (int i = 0; i < NUM_PAGES; i++) begin
                free_mk[i] = 1'b0;
                huge_mk[i] = 1'b0;
            end
            regs[0] = 16'd32768;
            regs[1] = 16'd160;
            regs[2] = 16'd256;
            regs[3] = 16'd512;
            fail_count = 0;
            drain_checked = 1'b0;
        end else begin
            if (cfg_we) regs[cfg_index] = cfg_wdata;
            // Compare the response first: it can never belong to a request taken at this edge.
            if (m_valid && m_ready) begin
                if (grants_due.size() == 0) begin
                    $error("response with no request outstanding");
                    fail_count++;
                end else begin
                    g = grants_due.pop_front();
                    if (m_page_out !== g.page) begin
                        $error("page_out: expected %0d, got %0d", g.page, m_page_out);
                        fail_count++;
                    end
                    if (m_status !== g.st) begin
                        $error("status: expected %0d, got %0d", g.st, m_status);
                        fail_count++;
                    end
                    if (m_clear_request !== g.clr) begin
                        $error("clear_request: expected %0d, got %0d", g.clr, m_clear_request);
                        fail_count++;
                    end
                    if (m_pages_granted !== g.cnt) begin
                        $error("pages_granted: expected %0d, got %0d", g.cnt, m_pages_granted);
                        fail_count++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                predict_grant(s_operation, s_zero_wanted, s_page_number, g);
                grants_due.push_back(g);
            end
            if (drain_done && !drain_checked) begin
                drain_checked = 1'b1;
                if (grants_due.size() != 0) begin
                    $error("%0d responses never arrived", grants_due.size());
                    fail_count++;
                end
            end
        end
    end

endmodule

### tb/page_frame_allocator_test.sv
// Top of the page frame allocator testbench: clock, reset, stimulus and verdict.
// Depends on pfa_pkg, the page_frame_allocator RTL and page_frame_allocator_checker.
`timescale 1ns / 1ps

module page_frame_allocator_test;
    import pfa_pkg::*;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_operation;
    logic        s_zero_wanted;
    logic [14:0] s_page_number;
    logic        m_valid;
    logic        m_ready;
    logic [14:0] m_page_out;
    logic [1:0]  m_status;
    logic        m_clear_request;
    logic [10:0] m_pages_granted;
    logic        cfg_we;
    logic [REG_IDX_W-1:0] cfg_index;
    logic [REG_W-1:0]     cfg_wdata;
    logic        drain_done;
    int          fail_count;

    // Handshake observations, registered at the rising edge and read at the falling one.
    logic        request_taken;
    op_t         ops_in_flight[$];
    logic [14:0] granted_pages[$];   // pages handed out and not yet given back
    int          idle_pct;
    int          stall_pct;
    int          requests_sent;
    int          responses_seen;
    int          huge_grants;

    page_frame_allocator u_top (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_zero_wanted  (s_zero_wanted),
        .s_page_number  (s_page_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_page_out     (m_page_out),
        .m_status       (m_status),
        .m_clear_request(m_clear_request),
        .m_pages_granted(m_pages_granted),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata)
    );

    page_frame_allocator_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_operation    (s_operation),
        .s_zero_wanted  (s_zero_wanted),
        .s_page_number  (s_page_number),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_page_out     (m_page_out),
        .m_status       (m_status),
        .m_clear_request(m_clear_request),
        .m_pages_granted(m_pages_granted),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .drain_done     (drain_done),
        .fail_count     (fail_count)
    );

    always begin
        aclk = 1'b1;
        #4;
        aclk = 1'b0;
        #4;
    end

    // The receiver stalls at random with the probability of the current phase.
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Track requests in flight so that the stimulus knows which pages it holds.
    // Successful allocations go into the pool of pages that later get freed.
    always @(posedge aclk) begin
        op_t op;
        request_taken <= s_valid && s_ready;
        if (aresetn && m_valid && m_ready) begin
            responses_seen++;
            if (ops_in_flight.size() != 0) begin
                op = ops_in_flight.pop_front();
                if (m_status == ST_OK && (op == OP_ALLOC || op == OP_HUGE)) begin
                    granted_pages.push_back(m_page_out);
                    if (op == OP_HUGE) huge_grants++;
                end
            end
        end
        if (aresetn && s_valid && s_ready) ops_in_flight.push_back(op_t'(s_operation));
    end

    // Present one request and hold it until the block takes it. Called and
    // returns at a falling edge; random idle cycles come first.
    task automatic send_request(input op_t op, input logic zw, input logic [14:0] pg);
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid       <= 1'b1;
        s_operation   <= op;
        s_zero_wanted <= zw;
        s_page_number <= pg;
        @(negedge aclk);
        while (!request_taken) @(negedge aclk);
        requests_sent++;
    endtask

    // Let every outstanding request come back before touching the registers.
    task automatic wait_quiet();
        s_valid <= 1'b0;
        @(negedge aclk);
        while (ops_in_flight.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_layout(input logic [15:0] pages, input logic [15:0] hs,
                                input logic [15:0] he, input logic [15:0] ke);
        cfg_we <= 1'b1;
        cfg_index <= REG_PAGES_IN_USE;
        cfg_wdata <= pages;
        @(negedge aclk);
        cfg_index <= REG_HOLE_START;
        cfg_wdata <= hs;
        @(negedge aclk);
        cfg_index <= REG_HOLE_END;
        cfg_wdata <= he;
        @(negedge aclk);
        cfg_index <= REG_KERNEL_END;
        cfg_wdata <= ke;
        @(negedge aclk);
        cfg_we <= 1'b0;
        @(negedge aclk);
    endtask

    // Frees one page: mostly a page that was handed out, otherwise a random one,
    // which often turns into a double free or a push of an unlisted page.
    task automatic free_some_page(input int mem_pages);
        logic [14:0] pg;
        int idx;
        if (granted_pages.size() != 0 && $urandom_range(99) < 60) begin
            idx = $urandom_range(granted_pages.size() - 1);
            pg = granted_pages[idx];
            granted_pages.delete(idx);
        end else if ($urandom_range(99) < 70) begin
            pg = 15'($urandom_range(mem_pages + 8));
        end else begin
            pg = 15'($urandom());
        end
        send_request(OP_FREE, 1'($urandom_range(1)), pg);
    endtask

    task automatic random_traffic(input int count, input int mem_pages);
        int r;
        for (int i = 0; i < count; i++) begin
            r = $urandom_range(99);
            if (r < 3)
                send_request(OP_HUGE, 1'($urandom_range(1)), 15'($urandom()));
            else if (r < 48)
                send_request(OP_ALLOC, 1'($urandom_range(1)), 15'($urandom()));
            else
                free_some_page(mem_pages);
        end
    endtask

    initial begin
        logic [14:0] huge_start;
        int pages, hs, he, ke;
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_operation   = OP_INIT;
        s_zero_wanted = 1'b0;
        s_page_number = '0;
        m_ready       = 1'b1;
        cfg_we        = 1'b0;
        cfg_index     = '0;
        cfg_wdata     = '0;
        drain_done    = 1'b0;
        idle_pct      = 0;
        stall_pct     = 0;
        requests_sent = 0;
        responses_seen = 0;
        huge_grants   = 0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part on the reset layout: full memory with the default hole.
        send_request(OP_ALLOC, 1'b1, 15'h7FFF);    // list still empty: must fail
        send_request(OP_HUGE, 1'b1, 15'h0000);     // no run on an empty list
        send_request(OP_INIT, 1'b1, 15'h7FFF);
        send_request(OP_ALLOC, 1'b1, 15'h0000);    // highest page comes first
        send_request(OP_ALLOC, 1'b0, 15'h2AAA);
        send_request(OP_FREE, 1'b1, 15'h7FFF);     // give back the first page
        send_request(OP_FREE, 1'b0, 15'h7FFF);     // double free
        send_request(OP_FREE, 1'b0, 15'h0000);     // page zero was never listed
        send_request(OP_FREE, 1'b0, 15'h0000);
        send_request(OP_FREE, 1'b1, 15'h5555);     // already free
        send_request(OP_FREE, 1'b0, 15'd200);      // page inside the hole
        send_request(OP_HUGE, 1'b1, 15'h0000);
        wait_quiet();
        huge_start = granted_pages[$];
        granted_pages.delete(granted_pages.size() - 1);
        // Give back one page of the block alone, then the block: that page is skipped.
        send_request(OP_FREE, 1'b0, huge_start + 15'd5);
        send_request(OP_FREE, 1'b1, huge_start);
        send_request(OP_FREE, 1'b0, huge_start);   // double free of the block
        wait_quiet();

        // No memory at all: init leaves the list empty.
        write_layout(16'd0, 16'd160, 16'd256, 16'd512);
        send_request(OP_INIT, 1'b0, 15'h0000);
        send_request(OP_ALLOC, 1'b1, 15'h0000);
        send_request(OP_HUGE, 1'b1, 15'h0000);
        send_request(OP_FREE, 1'b1, 15'd3);
        send_request(OP_ALLOC, 1'b1, 15'h0000);
        wait_quiet();
        granted_pages.delete();

        // Random phases over a range of layouts and idling patterns. Memory is
        // kept small so that huge searches and unlink walks stay short.
        for (int k = 0; k < 8; k++) begin
            case (k % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 52; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 52; end
                default: begin idle_pct = 14; stall_pct = 14; end
            endcase
            case (k)
                0: begin pages = 2600; hs = 160;  he = 256;   ke = 512;   end
                1: begin pages = 0;    hs = 0;    he = 0;     ke = 0;     end
                2: begin pages = 1;    hs = 32768; he = 32768; ke = 32768; end
                3: begin pages = 1100; hs = 900;  he = 300;   ke = 100;   end
                4: begin pages = 2048; hs = 0;    he = 0;     ke = 0;     end
                6: begin pages = 1500; hs = 0;    he = 32768; ke = 32768; end
                default: begin
                    pages = $urandom_range(3000, 1200);
                    hs = $urandom_range(pages);
                    he = $urandom_range(pages);
                    ke = $urandom_range(pages);
                end
            endcase
            write_layout(16'(pages), 16'(hs), 16'(he), 16'(ke));
            granted_pages.delete();
            send_request(OP_INIT, 1'($urandom_range(1)), 15'($urandom()));
            random_traffic(190, pages);
            wait_quiet();
        end

        repeat (64) @(negedge aclk);
        drain_done <= 1'b1;
        repeat (3) @(negedge aclk);
        $display("Sent %0d requests over 10 layouts, %0d responses, %0d huge blocks granted.",
                 requests_sent, responses_seen, huge_grants);
        if (fail_count == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    // Hard stop far beyond the slowest legal run, clearing pass included.
    initial begin
        #100_000_000;
        $display("Timeout waiting for the allocator.");
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

### filelist.f
hw/rtl/pfa_pkg.sv
hw/rtl/pfa_ram.sv
hw/rtl/page_frame_allocator.sv
hw/rtl/pfa_checker.sv
tb/page_frame_allocator_checker.sv
tb/page_frame_allocator_test.sv
